[rtl/core/cfbm_pkg.sv]
// Shared types and constants for the cassette FSK bit modulator.
`default_nettype none

package cfbm_pkg;

  localparam int unsigned CARRIER_W  = 14;
  localparam int unsigned HALF_W     = 5;
  localparam int unsigned BITS_W     = 4;
  localparam int unsigned FRAME_W    = 10;

  localparam logic [CARRIER_W-1:0] CARRIER_TICKS = 14'd15000;
  localparam logic [HALF_W-1:0]    TICKS_PER_BIT = 5'd16;
  localparam logic [BITS_W-1:0]    FRAME_BITS    = 4'd10;
  localparam logic [FRAME_W-1:0]   STOP_MARK     = 10'h200;

  typedef enum logic [1:0] {
    CMD_TICK        = 2'd0,
    CMD_LOAD        = 2'd1,
    CMD_CARRIER_ON  = 2'd2,
    CMD_CARRIER_OFF = 2'd3
  } cmd_t;

  typedef struct packed {
    logic tape_level;
    logic tone_phase;
    logic need_byte;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/cassette_fsk_bit_modulator_top.sv]
// Top level of the cassette FSK bit modulator.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid, in_ready, command, byte_value | sink
//   out     | out_valid, out_ready, tape_level,      | source
//           | tone_phase, need_byte                  |
//   cfg     | cfg_write_en, cfg_write_data           | sink
//
// One item per clock while in_ready is high; each result is registered.
// State updates at the input transfer; a result register plus skid stage
// lets the next item enter while a result waits, so in_ready drops only
// when both hold data. Synchronous reset clears all state and empties
// the output stages.
`default_nettype none

module cassette_fsk_bit_modulator_top
  import cfbm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic       cfg_write_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] command,
  input  wire logic [7:0] byte_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            tape_level,
  output logic            tone_phase,
  output logic            need_byte
);

  logic    fire;
  result_t result;
  result_t out_data;

  assign fire = in_valid && in_ready;

  cfbm_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .fire           (fire),
    .command        (command),
    .byte_value     (byte_value),
    .result         (result)
  );

  cfbm_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .push_data  (result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign tape_level = out_data.tape_level;
  assign tone_phase = out_data.tone_phase;
  assign need_byte  = out_data.need_byte;

endmodule

`default_nettype wire

[rtl/core/cfbm_engine.sv]
// Modulator state registers and the per-item update logic.
`default_nettype none

module cfbm_engine
  import cfbm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic       cfg_write_data,
  input  wire logic       fire,
  input  wire logic [1:0] command,
  input  wire logic [7:0] byte_value,
  output result_t         result
);

  logic                 motor;
  logic [CARRIER_W-1:0] carrier_left, carrier_left_next;
  logic [BITS_W-1:0]    bits_left, bits_left_next;
  logic [HALF_W-1:0]    half_left, half_left_next;
  logic [FRAME_W-1:0]   frame_shift, frame_shift_next;
  logic                 level, level_next;
  logic                 phase, phase_next;
  logic                 need;
  logic [CARRIER_W-1:0] carrier_dec;
  logic [HALF_W-1:0]    half_dec;
  logic [BITS_W-1:0]    bits_dec;
  cmd_t                 cmd;

  assign cmd         = cmd_t'(command);
  assign carrier_dec = carrier_left - 1'b1;
  assign half_dec    = half_left - 1'b1;
  assign bits_dec    = bits_left - 1'b1;

  always_comb begin
    carrier_left_next = carrier_left;
    bits_left_next    = bits_left;
    half_left_next    = half_left;
    frame_shift_next  = frame_shift;
    level_next        = level;
    phase_next        = phase;
    need              = 1'b0;
    case (cmd)
      CMD_TICK: begin
        phase_next = ~phase;
        if (motor) begin
          if (carrier_left != '0) begin
            carrier_left_next = carrier_dec;
            level_next        = carrier_dec[0];
            need              = (carrier_dec == '0);
          end else if (bits_left != '0) begin
            level_next     = frame_shift[0] ? half_left[0] : half_left[1];
            half_left_next = half_dec;
            if (half_dec == '0) begin
              bits_left_next   = bits_dec;
              frame_shift_next = frame_shift >> 1;
              if (bits_dec == '0) begin
                need = 1'b1;
              end else begin
                half_left_next = TICKS_PER_BIT;
              end
            end
          end else begin
            need = 1'b1;
          end
        end
      end
      CMD_LOAD: begin
        bits_left_next   = FRAME_BITS;
        half_left_next   = TICKS_PER_BIT;
        frame_shift_next = STOP_MARK | {1'b0, byte_value, 1'b0};
      end
      CMD_CARRIER_ON: begin
        carrier_left_next = CARRIER_TICKS;
      end
      CMD_CARRIER_OFF: begin
        carrier_left_next = '0;
      end
      default: begin
        carrier_left_next = carrier_left;
      end
    endcase
  end

  assign result.tape_level = level_next;
  assign result.tone_phase = phase_next;
  assign result.need_byte  = need;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor        <= 1'b0;
      carrier_left <= '0;
      bits_left    <= '0;
      half_left    <= '0;
      frame_shift  <= '0;
      level        <= 1'b0;
      phase        <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        motor <= cfg_write_data;
      end
      if (fire) begin
        carrier_left <= carrier_left_next;
        bits_left    <= bits_left_next;
        half_left    <= half_left_next;
        frame_shift  <= frame_shift_next;
        level        <= level_next;
        phase        <= phase_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/cfbm_out_buf.sv]
// Result register with a skid stage on the output channel.
`default_nettype none

module cfbm_out_buf
  import cfbm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         push_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop        = out_valid && out_ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/cfbm_checker.sv]
// Port-level checker for the modulator top, with its bind.
`default_nettype none

module cfbm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic tape_level,
  input wire logic tone_phase,
  input wire logic need_byte
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tape_level)
      && $stable(tone_phase) && $stable(need_byte))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output not empty after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !(in_valid && in_ready) |=> in_ready)
    else $error("input still blocked after a transfer out");

endmodule

bind cassette_fsk_bit_modulator_top cfbm_checker u_cfbm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .tape_level (tape_level),
  .tone_phase (tone_phase),
  .need_byte  (need_byte)
);

`default_nettype wire

[tb/cassette_fsk_checker.sv]
// Checker for the cassette FSK bit modulator: predicts each result and compares transfers.
module cassette_fsk_checker
  import cfbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] command,
  input  logic [7:0] byte_value,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       tape_level,
  input  logic       tone_phase,
  input  logic       need_byte,
  output int         failures,
  output int         due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                 motor_on;
  logic [CARRIER_W-1:0] tone_left;
  logic [BITS_W-1:0]    frame_bits_left;
  logic [HALF_W-1:0]    half_left;
  logic [FRAME_W-1:0]   frame_sr;
  logic                 level;
  logic                 phase;

  result_t due_results[$];
  int      err_count = 0;

  assign failures = err_count;

  // Advances the modulator model by one transfer and returns the result it produces.
  function automatic result_t modulate(cmd_t cmd, logic [7:0] data);
    result_t r;
    logic    req;
    req = 1'b0;
    case (cmd)
      CMD_TICK: begin
        phase = ~phase;
        if (motor_on) begin
          if (tone_left != '0) begin
            tone_left = tone_left - 1'b1;
            level = tone_left[0];
            req = (tone_left == '0);
          end else if (frame_bits_left != '0) begin
            level = frame_sr[0] ? half_left[0] : half_left[1];
            half_left = half_left - 1'b1;
            if (half_left == '0) begin
              frame_bits_left = frame_bits_left - 1'b1;
              frame_sr = frame_sr >> 1;
              if (frame_bits_left == '0) begin
                req = 1'b1;
              end else begin
                half_left = TICKS_PER_BIT;
              end
            end
          end else begin
            req = 1'b1;
          end
        end
      end
      CMD_LOAD: begin
        frame_bits_left = FRAME_BITS;
        half_left = TICKS_PER_BIT;
        frame_sr = {1'b0, data, 1'b0} | STOP_MARK;
      end
      CMD_CARRIER_ON: begin
        tone_left = CARRIER_TICKS;
      end
      default: begin
        tone_left = '0;
      end
    endcase
    r.tape_level = level;
    r.tone_phase = phase;
    r.need_byte  = req;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      motor_on        = 1'b0;
      tone_left       = '0;
      frame_bits_left = '0;
      half_left       = '0;
      frame_sr        = '0;
      level           = 1'b0;
      phase           = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_write_en) begin
        motor_on = cfg_write_data;
      end
      if (in_valid && in_ready) begin
        due_results.push_back(modulate(cmd_t'(command), byte_value));
      end
      if (out_valid && out_ready) begin
        got.tape_level = tape_level;
        got.tone_phase = tone_phase;
        got.need_byte  = need_byte;
        if (due_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result level=%b phase=%b need=%b", $time,
                   got.tape_level, got.tone_phase, got.need_byte);
        end else begin
          want = due_results.pop_front();
          if (got.tape_level !== want.tape_level) begin
            err_count++;
            $display("%0t: tape_level expected %b actual %b", $time,
                     want.tape_level, got.tape_level);
          end
          if (got.tone_phase !== want.tone_phase) begin
            err_count++;
            $display("%0t: tone_phase expected %b actual %b", $time,
                     want.tone_phase, got.tone_phase);
          end
          if (got.need_byte !== want.need_byte) begin
            err_count++;
            $display("%0t: need_byte expected %b actual %b", $time,
                     want.need_byte, got.need_byte);
          end
        end
      end
    end
    due_count <= due_results.size();
  end

endmodule

[tb/cassette_fsk_bit_modulator_top_tb.sv]
// Testbench top for the cassette FSK bit modulator: stimulus, flow control and verdict.
module cassette_fsk_bit_modulator_top_tb
  import cfbm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1900;
  localparam int QUIET_AFTER  = 1700;
  localparam int STALL_LIMIT  = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic       cfg_write_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] command = CMD_TICK;
  logic [7:0] byte_value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       tape_level;
  logic       tone_phase;
  logic       need_byte;

  int   failures;
  int   due_count;
  logic quiet = 1'b0;
  bit   tx_calm = 1'b0;
  int   items_sent = 0;
  int   loads_sent = 0;
  int   tones_sent = 0;
  int   rx_stall_left = 0;
  int   rx_calm_left = 0;
  int   idle_cycles = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  cassette_fsk_bit_modulator_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .byte_value    (byte_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tape_level    (tape_level),
    .tone_phase    (tone_phase),
    .need_byte     (need_byte)
  );

  cassette_fsk_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .byte_value    (byte_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tape_level    (tape_level),
    .tone_phase    (tone_phase),
    .need_byte     (need_byte),
    .failures      (failures),
    .due_count     (due_count)
  );

  // receiver backpressure: random stall bursts, with calm stretches
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready <= 1'b1;
      rx_stall_left <= 0;
      rx_calm_left <= 0;
    end else if (rx_stall_left != 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_calm_left != 0) begin
      out_ready <= 1'b1;
      rx_calm_left <= rx_calm_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 63) == 0) begin
        rx_calm_left <= $urandom_range(20, 200);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_item(cmd_t cmd, logic [7:0] data);
    if (!quiet && !tx_calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    byte_value <= data;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (cmd == CMD_LOAD) loads_sent++;
    if (cmd == CMD_CARRIER_ON) tones_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(CMD_TICK, 8'($urandom));
  endtask

  // motor register is only written once every result has been transferred
  task automatic set_motor(logic on);
    in_valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= on;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    int random_start;
    int n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle line with motor on, then motor off
    set_motor(1'b1);
    send_ticks(2);
    set_motor(1'b0);
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_LOAD, 8'hA5);
    send_item(CMD_CARRIER_ON, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_CARRIER_OFF, 8'hFF);
    // queued byte starts, gets replaced, then a tone preempts it
    set_motor(1'b1);
    send_ticks(3);
    send_item(CMD_LOAD, 8'h00);
    send_ticks(2);
    send_item(CMD_LOAD, 8'hFF);
    send_ticks(2);
    send_item(CMD_CARRIER_ON, 8'h5A);
    send_ticks(2);
    send_item(CMD_CARRIER_ON, 8'hFF);
    send_ticks(1);
    send_item(CMD_CARRIER_OFF, 8'h00);
    send_ticks(2);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (items_sent - random_start >= QUIET_AFTER && !quiet) begin
        set_motor(1'b1);
        quiet <= 1'b1;
      end
      if (!quiet && $urandom_range(0, 11) == 0) begin
        set_motor($urandom_range(0, 3) != 0);
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          send_item(CMD_LOAD, 8'($urandom));
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 159) : $urandom_range(160, 175);
          send_ticks(n);
        end
        12, 13, 14: begin
          send_item(CMD_CARRIER_ON, 8'($urandom));
          send_ticks($urandom_range(1, 60));
          if ($urandom_range(0, 2) == 0) begin
            send_item(CMD_CARRIER_ON, 8'($urandom));
            send_ticks($urandom_range(1, 20));
          end
          send_item(CMD_CARRIER_OFF, 8'($urandom));
          send_ticks($urandom_range(0, 4));
        end
        default: begin
          repeat ($urandom_range(1, 6)) send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom));
        end
      endcase
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d items: %0d byte loads, %0d tone starts, motor on and off,", items_sent,
             loads_sent, tones_sent);
    $display("including full byte frames, tone cancels and byte replacement under a tone.");
    if (failures == 0 && due_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[cassette_fsk_bit_modulator_top.f]
rtl/core/cfbm_pkg.sv
rtl/core/cfbm_engine.sv
rtl/core/cfbm_out_buf.sv
rtl/core/cassette_fsk_bit_modulator_top.sv
rtl/core/cfbm_checker.sv
tb/cassette_fsk_checker.sv
tb/cassette_fsk_bit_modulator_top_tb.sv
